@@ rtl/spa_pkg.sv @@
package spa_pkg;

    localparam int PAL_COUNT = 16;
    localparam int PAL_COLORS = 15;
    localparam int IDX_W = 4;
    localparam int LEN_W = 5;
    localparam int COLOR_W = 16;
    localparam int COUNT_W = 8;

    localparam logic [1:0] ST_REUSED   = 2'd0;
    localparam logic [1:0] ST_NEW      = 2'd1;
    localparam logic [1:0] ST_NO_FREE  = 2'd2;
    localparam logic [1:0] ST_TOO_MANY = 2'd3;

    typedef logic [PAL_COLORS-1:0][COLOR_W-1:0] color_row_t;

    // Broadcast from the controller to every palette cell
    typedef struct packed {
        logic               cmp_en;
        logic               cmp_first;
        logic [IDX_W-1:0]   cmp_sel;
        logic [COLOR_W-1:0] color;
        logic               release_en;
        logic [IDX_W-1:0]   release_idx;
        logic               commit;
        logic [LEN_W-1:0]   req_len;
        color_row_t         req_colors;
    } cell_cmd_t;

    // Priority chain passed from cell to cell
    typedef struct packed {
        logic             free_seen;
        logic             found;
        logic [IDX_W-1:0] free_idx;
        logic [IDX_W-1:0] found_idx;
    } chain_t;

endpackage

@@ rtl/shared_palette_allocator_top.sv @@
// Shared palette allocator: 16 reference-counted palettes of 15 colors.
// Input channel (s_): a beat is either one color of a load request
// (s_kind = 0, s_last_color marks the final color) or a release
// (s_kind = 1) that decrements the count of s_release_index.
// Result channel (m_): one beat per finished load request carrying
// m_status and m_palette_index.
// Each palette lives in its own cell; the cells compare every incoming
// color against their stored entry as it arrives, so matching is done by
// the time the last color lands. Colors and releases are each taken as one beat.
// For the final color the beat is accepted, then the cell chain
// resolves first-free and first-match and the result is registered,
// appearing on m_ once the output slot is free.
// While m_ holds a result the receiver has not taken, colors and releases
// are still accepted; a final color is accepted too, but then s_ready
// stays low until the output slot frees and the new result is registered.
// Reset clears all palettes to zero, all counts and the pending request.

module shared_palette_allocator_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [spa_pkg::COLOR_W-1:0] s_color,
    input  logic                        s_last_color,
    input  logic [spa_pkg::IDX_W-1:0]   s_release_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [spa_pkg::IDX_W-1:0]   m_palette_index
);

    localparam logic [spa_pkg::LEN_W-1:0] MaxLen = spa_pkg::LEN_W'(spa_pkg::PAL_COLORS);

    logic                        finish_reg;
    logic [spa_pkg::LEN_W-1:0]   len_reg;
    spa_pkg::color_row_t         req_colors_reg;
    logic                        m_valid_reg;
    logic [1:0]                  m_status_reg;
    logic [spa_pkg::IDX_W-1:0]   m_palette_index_reg;

    logic                        accept;
    logic                        color_acc;
    logic                        fire;
    logic                        overflow;
    logic [1:0]                  status_next;
    logic [spa_pkg::IDX_W-1:0]   index_next;
    spa_pkg::cell_cmd_t          cmd;
    spa_pkg::chain_t             chain [spa_pkg::PAL_COUNT+1];

    assign s_ready = !finish_reg;
    assign accept = s_valid && s_ready;
    assign color_acc = accept && !s_kind;
    assign fire = finish_reg && (!m_valid_reg || m_ready);
    assign overflow = len_reg > MaxLen;

    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_palette_index = m_palette_index_reg;

    always_comb begin
        cmd.cmp_en = color_acc && (len_reg < MaxLen);
        cmd.cmp_first = (len_reg == '0);
        cmd.cmp_sel = len_reg[spa_pkg::IDX_W-1:0];
        cmd.color = s_color;
        cmd.release_en = accept && s_kind;
        cmd.release_idx = s_release_index;
        cmd.commit = fire && !overflow;
        cmd.req_len = len_reg;
        cmd.req_colors = req_colors_reg;
    end

    assign chain[0] = '0;

    for (genvar p = 0; p < spa_pkg::PAL_COUNT; p++) begin : g_cell
        spa_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (spa_pkg::IDX_W'(p)),
            .cmd       (cmd),
            .chain_in  (chain[p]),
            .chain_out (chain[p+1]),
            .found_any (chain[spa_pkg::PAL_COUNT].found)
        );
    end

    always_comb begin
        if (overflow) begin
            status_next = spa_pkg::ST_TOO_MANY;
            index_next = '0;
        end else if (chain[spa_pkg::PAL_COUNT].found) begin
            status_next = spa_pkg::ST_REUSED;
            index_next = chain[spa_pkg::PAL_COUNT].found_idx;
        end else if (chain[spa_pkg::PAL_COUNT].free_seen) begin
            status_next = spa_pkg::ST_NEW;
            index_next = chain[spa_pkg::PAL_COUNT].free_idx;
        end else begin
            status_next = spa_pkg::ST_NO_FREE;
            index_next = '0;
        end
    end

    // request buffer; excess colors are dropped
    always_ff @(posedge aclk) begin
        if (color_acc && len_reg < MaxLen) begin
            req_colors_reg[len_reg[spa_pkg::IDX_W-1:0]] <= s_color;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finish_reg <= 1'b0;
            len_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (color_acc) begin
                if (len_reg <= MaxLen) begin
                    len_reg <= len_reg + 1'b1;
                end
                if (s_last_color) begin
                    finish_reg <= 1'b1;
                end
            end
            if (fire) begin
                finish_reg <= 1'b0;
                len_reg <= '0;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_status_reg <= status_next;
            m_palette_index_reg <= index_next;
        end
    end

endmodule

@@ rtl/spa_cell.sv @@
module spa_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [spa_pkg::IDX_W-1:0] cell_idx,
    input  spa_pkg::cell_cmd_t      cmd,
    input  spa_pkg::chain_t         chain_in,
    output spa_pkg::chain_t         chain_out,
    input  logic                    found_any
);

    logic [spa_pkg::COLOR_W-1:0] colors_reg [spa_pkg::PAL_COLORS];
    logic [spa_pkg::COUNT_W-1:0] count_reg;
    logic                        match_reg;
    logic                        eq;
    logic                        free_here;
    logic                        found_here;
    logic                        take;
    logic                        fill;

    always_comb begin
        eq = (colors_reg[cmd.cmp_sel] == cmd.color);
        free_here = (count_reg == '0) && !chain_in.free_seen;
        found_here = !free_here && match_reg && !chain_in.found;
        fill = !found_any && free_here;
        take = found_here || fill;

        chain_out.free_seen = chain_in.free_seen || free_here;
        chain_out.found = chain_in.found || found_here;
        chain_out.free_idx = free_here ? cell_idx : chain_in.free_idx;
        chain_out.found_idx = found_here ? cell_idx : chain_in.found_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            match_reg <= 1'b0;
            for (int i = 0; i < spa_pkg::PAL_COLORS; i++) begin
                colors_reg[i] <= '0;
            end
        end else begin
            if (cmd.cmp_en) begin
                match_reg <= eq && (cmd.cmp_first || match_reg);
            end
            if (cmd.release_en && cmd.release_idx == cell_idx && count_reg != '0) begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.commit && take && count_reg != '1) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.commit && fill) begin
                // copy only the colors this request supplied
                for (int i = 0; i < spa_pkg::PAL_COLORS; i++) begin
                    if (spa_pkg::LEN_W'(i) < cmd.req_len) begin
                        colors_reg[i] <= cmd.req_colors[i];
                    end
                end
            end
        end
    end

endmodule

@@ verif/palette_alloc_checker.sv @@
module palette_alloc_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_kind,
    input  logic [spa_pkg::COLOR_W-1:0] s_color,
    input  logic                        s_last_color,
    input  logic [spa_pkg::IDX_W-1:0]   s_release_index,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [1:0]                  m_status,
    input  logic [spa_pkg::IDX_W-1:0]   m_palette_index,
    output int                          mismatches,
    output int                          backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]                status;
        logic [spa_pkg::IDX_W-1:0] index;
    } alloc_t;

    logic [spa_pkg::COLOR_W-1:0] pal_mem [spa_pkg::PAL_COUNT][spa_pkg::PAL_COLORS];
    logic [spa_pkg::COUNT_W-1:0] use_count [spa_pkg::PAL_COUNT];
    logic [spa_pkg::COLOR_W-1:0] req_buf [spa_pkg::PAL_COLORS];
    int                          req_len;
    alloc_t                      alloc_q [$];
    alloc_t                      oldest;

    initial begin
        mismatches = 0;
        backlog = 0;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    task automatic clear_palettes();
        for (int p = 0; p < spa_pkg::PAL_COUNT; p++) begin
            use_count[p] = '0;
            for (int i = 0; i < spa_pkg::PAL_COLORS; i++) begin
                pal_mem[p][i] = '0;
            end
        end
        for (int i = 0; i < spa_pkg::PAL_COLORS; i++) begin
            req_buf[i] = '0;
        end
        req_len = 0;
    endtask

    // Scan palettes in order: the first idle one is held aside as the free slot
    // and skipped, every other one is tried against the leading request colors.
    task automatic resolve_load();
        int     len;
        int     free_slot;
        int     pick;
        logic   have_free;
        logic   hit;
        logic   same;
        alloc_t res;
        len = req_len;
        req_len = 0;
        have_free = 1'b0;
        hit = 1'b0;
        free_slot = 0;
        pick = 0;
        if (len > spa_pkg::PAL_COLORS) begin
            res.status = spa_pkg::ST_TOO_MANY;
            res.index = '0;
            alloc_q.insert(alloc_q.size(), res);
            return;
        end
        for (int p = 0; p < spa_pkg::PAL_COUNT && !hit; p++) begin
            if (use_count[p] == 0 && !have_free) begin
                have_free = 1'b1;
                free_slot = p;
            end else begin
                same = 1'b1;
                for (int i = 0; i < len; i++) begin
                    if (pal_mem[p][i] != req_buf[i]) same = 1'b0;
                end
                if (same) begin
                    hit = 1'b1;
                    pick = p;
                end
            end
        end
        if (hit) begin
            res.status = spa_pkg::ST_REUSED;
        end else if (have_free) begin
            pick = free_slot;
            for (int i = 0; i < len; i++) begin
                pal_mem[pick][i] = req_buf[i];
            end
            res.status = spa_pkg::ST_NEW;
        end else begin
            res.status = spa_pkg::ST_NO_FREE;
            res.index = '0;
            alloc_q.insert(alloc_q.size(), res);
            return;
        end
        if (use_count[pick] != '1) use_count[pick]++;
        res.index = pick[spa_pkg::IDX_W-1:0];
        alloc_q.insert(alloc_q.size(), res);
    endtask

    task automatic take_beat(input logic kind, input logic [spa_pkg::COLOR_W-1:0] color,
                             input logic last, input logic [spa_pkg::IDX_W-1:0] rel);
        if (kind) begin
            if (int'(rel) < spa_pkg::PAL_COUNT && use_count[rel] != 0) use_count[rel]--;
            return;
        end
        // drop colors past the palette size but keep counting to flag overflow
        if (req_len < spa_pkg::PAL_COLORS) req_buf[req_len] = color;
        if (req_len <= spa_pkg::PAL_COLORS) req_len++;
        if (last) resolve_load();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_palettes();
            alloc_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                take_beat(s_kind, s_color, s_last_color, s_release_index);
            end
            if (m_valid && m_ready) begin
                if (alloc_q.size() == 0) begin
                    report_mismatch("result beat with none pending, status", -1,
                                    int'(m_status));
                end else begin
                    oldest = alloc_q.pop_front();
                    if (m_status !== oldest.status) begin
                        report_mismatch("status", int'(oldest.status), int'(m_status));
                    end
                    if (m_palette_index !== oldest.index) begin
                        report_mismatch("palette_index", int'(oldest.index),
                                        int'(m_palette_index));
                    end
                end
            end
        end
        backlog <= alloc_q.size();
    end

endmodule

@@ verif/tb_top.sv @@
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int ITEM_TARGET = 1400;
    localparam int BANK_SIZE = 24;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_kind = 1'b0;
    logic [spa_pkg::COLOR_W-1:0] s_color = '0;
    logic                        s_last_color = 1'b0;
    logic [spa_pkg::IDX_W-1:0]   s_release_index = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [1:0]                  m_status;
    logic [spa_pkg::IDX_W-1:0]   m_palette_index;

    int mismatches;
    int backlog;
    int cycle_count = 0;
    int beats_sent = 0;
    logic steady = 1'b0;

    logic [spa_pkg::COLOR_W-1:0] load_words [20];
    logic [spa_pkg::COLOR_W-1:0] seq_bank [BANK_SIZE][spa_pkg::PAL_COLORS];
    int                          seq_len [BANK_SIZE];
    int                          bank_fill = 0;

    shared_palette_allocator_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_color         (s_color),
        .s_last_color    (s_last_color),
        .s_release_index (s_release_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_palette_index (m_palette_index)
    );

    palette_alloc_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_color         (s_color),
        .s_last_color    (s_last_color),
        .s_release_index (s_release_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_palette_index (m_palette_index),
        .mismatches      (mismatches),
        .backlog         (backlog)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= steady ? 1'b1 : ($urandom_range(99) >= 20);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Hold the beat until accepted; outside the steady window valid is lowered at random between beats.
    task automatic push_beat(input logic kind, input logic [spa_pkg::COLOR_W-1:0] color,
                             input logic last, input logic [spa_pkg::IDX_W-1:0] rel);
        while (!steady && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_color <= color;
        s_last_color <= last;
        s_release_index <= rel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
        steady = (beats_sent >= 600 && beats_sent < 800);
    endtask

    task automatic send_release(input logic [spa_pkg::IDX_W-1:0] idx);
        push_beat(1'b1, spa_pkg::COLOR_W'($urandom_range(65535)), 1'($urandom_range(1)), idx);
    endtask

    // Releases may land in the middle of a load; they must not disturb it.
    task automatic send_load(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 10) send_release(spa_pkg::IDX_W'($urandom_range(15)));
            push_beat(1'b0, load_words[i], i == n - 1, spa_pkg::IDX_W'($urandom_range(15)));
        end
    endtask

    task automatic random_load();
        int                          r;
        int                          n;
        int                          b;
        logic [spa_pkg::COLOR_W-1:0] fill;
        r = $urandom_range(99);
        if (r < 50 && bank_fill > 0) begin
            // replay a known palette, whole or as a prefix
            b = $urandom_range(bank_fill - 1);
            n = (r < 35) ? seq_len[b] : $urandom_range(seq_len[b], 1);
            for (int i = 0; i < n; i++) load_words[i] = seq_bank[b][i];
        end else if (r < 55) begin
            n = $urandom_range(19, 16);
            for (int i = 0; i < n; i++) begin
                load_words[i] = spa_pkg::COLOR_W'($urandom_range(65535));
            end
        end else if (r < 60) begin
            n = $urandom_range(15, 1);
            fill = $urandom_range(1) ? '1 : '0;
            for (int i = 0; i < n; i++) load_words[i] = fill;
        end else begin
            n = ($urandom_range(9) < 7) ? $urandom_range(4, 1) : $urandom_range(15, 1);
            if (bank_fill < BANK_SIZE) begin
                b = bank_fill;
                bank_fill++;
            end else begin
                b = $urandom_range(BANK_SIZE - 1);
            end
            seq_len[b] = n;
            for (int i = 0; i < n; i++) begin
                load_words[i] = spa_pkg::COLOR_W'($urandom_range(65535));
                seq_bank[b][i] = load_words[i];
            end
        end
        send_load(n);
    endtask

    initial begin
        logic drain;
        int   next_flip;
        drain = 1'b0;
        next_flip = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // a lone zero color matches an untouched palette behind the free one
        load_words[0] = 16'h0000;
        send_load(1);
        load_words[0] = 16'hFFFF;
        load_words[1] = 16'h7FFF;
        load_words[2] = 16'h8000;
        send_load(3);
        send_load(3);
        send_load(1);
        send_release(4'd0);
        send_release(4'd0);
        send_release(4'd0);
        send_release(4'd15);
        for (int i = 0; i < 16; i++) load_words[i] = i[0] ? 16'h5555 : 16'hAAAA;
        send_load(16);

        // drive one palette's count into saturation
        for (int k = 0; k < 280; k++) begin
            load_words[0] = 16'h5A5A;
            send_load(1);
        end

        while (beats_sent < ITEM_TARGET) begin
            if (beats_sent >= next_flip) begin
                drain = ($urandom_range(2) == 0);
                next_flip = beats_sent + 40;
            end
            if ($urandom_range(99) < (drain ? 55 : 8)) begin
                send_release(spa_pkg::IDX_W'($urandom_range(15)));
            end else begin
                random_load();
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (backlog != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
